// ===== sv/sos_pkg.sv =====
// Shared widths, codes and reset values for the sweep object segmenter.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package sos_pkg;

    // Field widths.
    localparam int ANGLE_W = 8;
    localparam int DIST_W  = 12;
    localparam int WIDTH_W = 8;
    localparam int ID_W    = 4;
    localparam int KIND_W  = 2;
    localparam int SUM_W   = 19;
    localparam int CNT_W   = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Run accumulation limits.
    localparam logic [SUM_W-1:0] SUM_MAX    = '1;
    localparam int               CNT_HW_MAX = 127;
    localparam logic [DIST_W-1:0] AVG_MAX   = '1;

    // Default sweep length bound.
    localparam int DEF_MAX_SWEEP_POINTS = 128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VALID_MIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALID_MAX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_WIDTH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OBJ_QUOTA      = 3'd5;

    // Configuration reset values.
    localparam logic [DIST_W-1:0]  RST_VALID_MIN      = 12'd32;
    localparam logic [DIST_W-1:0]  RST_VALID_MAX      = 12'd4000;
    localparam logic [DIST_W-1:0]  RST_OBJECT_LIMIT   = 12'd1600;
    localparam logic [DIST_W-1:0]  RST_JUMP_THRESHOLD = 12'd240;
    localparam logic [WIDTH_W-1:0] RST_MIN_WIDTH      = 8'd4;
    localparam logic [ID_W-1:0]    RST_OBJ_QUOTA      = 4'd10;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_OBJECT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SMALLEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NO_TARGET = 2'd2;

endpackage

// ===== sv/sweep_object_segmenter.sv =====
// Top level of the sweep object segmenter: sequencer, run state and result register.
// Depends on sos_pkg and instantiates the serial divider sos_div.
`timescale 1ns / 1ps

// The segmenter takes one range sweep point per transfer and is busy until every
// result caused by that point has been transferred out, so o_in_stall stays high
// meanwhile. A point that closes no reportable object and is not the last point
// is only accepted and evaluated. A point that closes a reported object runs
// the run's distance sum through a serial divider that yields one quotient bit per
// cycle, and then waits on the output side; the last point adds the final state
// and one more output transfer for the final result.
// Configuration writes are taken in every cycle (o_cfg_ready is always high) and
// apply from the next point on; they should only be issued while no point is in
// work. At most two results follow one point: the object, then the final result
// of the sweep, which carries o_last high.
module sweep_object_segmenter #(
    parameter int MAX_SWEEP_POINTS = sos_pkg::DEF_MAX_SWEEP_POINTS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input point channel.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [sos_pkg::ANGLE_W-1:0]       i_angle,
    input  logic [sos_pkg::DIST_W-1:0]        i_distance,
    input  logic                              i_last_point,
    // Result channel.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [sos_pkg::KIND_W-1:0]        o_kind,
    output logic [sos_pkg::ID_W-1:0]          o_object_id,
    output logic [sos_pkg::ANGLE_W-1:0]       o_mid_angle,
    output logic [sos_pkg::WIDTH_W-1:0]       o_object_width,
    output logic [sos_pkg::DIST_W-1:0]        o_avg_distance,
    output logic                              o_last,
    // Configuration write channel.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sos_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sos_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // The run length counter saturates at the smaller of the sweep bound less one
    // and what the counter can hold.
    localparam int CNT_CAP = (MAX_SWEEP_POINTS - 1 < sos_pkg::CNT_HW_MAX)
                             ? (MAX_SWEEP_POINTS - 1) : sos_pkg::CNT_HW_MAX;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state;

    // Configuration registers.
    logic [sos_pkg::DIST_W-1:0]  r_valid_min, r_valid_max, r_object_limit, r_jump_threshold;
    logic [sos_pkg::WIDTH_W-1:0] r_min_width;
    logic [sos_pkg::ID_W-1:0]    r_obj_quota;

    // Point held while it is worked on.
    logic [sos_pkg::ANGLE_W-1:0] r_ang;
    logic [sos_pkg::DIST_W-1:0]  r_dist;
    logic                        r_last;

    // Sweep state.
    logic                        r_inside;
    logic [sos_pkg::ANGLE_W-1:0] r_run_start;
    logic [sos_pkg::SUM_W-1:0]   r_sum;
    logic [sos_pkg::CNT_W-1:0]   r_count;
    logic [sos_pkg::DIST_W-1:0]  r_prev_dist;
    logic [sos_pkg::ANGLE_W-1:0] r_prev_ang;
    logic [sos_pkg::ID_W-1:0]    r_objects_found;
    logic [sos_pkg::WIDTH_W-1:0] r_best_width;
    logic [sos_pkg::ANGLE_W-1:0] r_best_angle;
    logic [sos_pkg::ID_W-1:0]    r_best_id;

    // Object waiting on the divider.
    logic [sos_pkg::ID_W-1:0]    r_pend_id;
    logic [sos_pkg::ANGLE_W-1:0] r_pend_ctr;
    logic [sos_pkg::WIDTH_W-1:0] r_pend_width;

    // Result register.
    logic                        r_out_valid;
    logic [sos_pkg::KIND_W-1:0]  r_out_kind;
    logic [sos_pkg::ID_W-1:0]    r_out_id;
    logic [sos_pkg::ANGLE_W-1:0] r_out_ctr;
    logic [sos_pkg::WIDTH_W-1:0] r_out_width;
    logic [sos_pkg::DIST_W-1:0]  r_out_avg;
    logic                        r_out_last;

    // Evaluation of the held point against the sweep state.
    logic                        is_obj;
    logic                        jump;
    logic                        run_end;
    logic                        qualify;
    logic [sos_pkg::SUM_W:0]     sum_add;
    logic [sos_pkg::SUM_W-1:0]   n_sum;
    logic [sos_pkg::CNT_W-1:0]   n_count;
    logic [sos_pkg::WIDTH_W-1:0] run_width;
    logic [sos_pkg::ANGLE_W:0]   ang_sum;
    logic [sos_pkg::ANGLE_W-1:0] run_ctr;
    logic [sos_pkg::ID_W-1:0]    n_id;

    logic                        in_xfer, out_xfer, cfg_xfer;
    logic                        div_start, div_busy, div_done;
    logic [sos_pkg::SUM_W-1:0]   div_quo;
    logic [sos_pkg::DIST_W-1:0]  avg_capped;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;
    assign cfg_xfer = i_cfg_valid && o_cfg_ready;

    always_comb begin
        is_obj = (r_dist >= r_valid_min) && (r_dist <= r_valid_max)
                 && (r_dist < r_object_limit);
        jump   = {1'b0, r_dist} > ({1'b0, r_prev_dist} + {1'b0, r_jump_threshold});
        sum_add = {1'b0, r_sum} + (sos_pkg::SUM_W + 1)'(r_dist);
        n_sum   = r_sum;
        n_count = r_count;
        if (is_obj) begin
            n_sum = sum_add[sos_pkg::SUM_W] ? sos_pkg::SUM_MAX : sum_add[sos_pkg::SUM_W-1:0];
            if (r_count < sos_pkg::CNT_W'(CNT_CAP)) begin
                n_count = r_count + 1'b1;
            end
        end
        // The run's end angle is the angle of the point before the one ending it.
        run_width = (r_prev_ang >= r_run_start) ? (r_prev_ang - r_run_start)
                                                : (r_run_start - r_prev_ang);
        ang_sum   = {1'b0, r_run_start} + {1'b0, r_prev_ang};
        run_ctr   = ang_sum[sos_pkg::ANGLE_W:1];
        run_end   = r_inside && (!is_obj || r_last || jump);
        qualify   = run_end && (run_width >= r_min_width)
                    && (r_objects_found < r_obj_quota);
        n_id      = r_objects_found + 1'b1;
    end

    // The divider is started from the updated sum and count as the run closes.
    assign div_start = (r_state == S_EVAL) && qualify;

    sos_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_sum),
        .i_divisor  (n_count),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign avg_capped = (div_quo[sos_pkg::SUM_W-1:sos_pkg::DIST_W] != '0)
                        ? sos_pkg::AVG_MAX : div_quo[sos_pkg::DIST_W-1:0];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_min      <= sos_pkg::RST_VALID_MIN;
            r_valid_max      <= sos_pkg::RST_VALID_MAX;
            r_object_limit   <= sos_pkg::RST_OBJECT_LIMIT;
            r_jump_threshold <= sos_pkg::RST_JUMP_THRESHOLD;
            r_min_width      <= sos_pkg::RST_MIN_WIDTH;
            r_obj_quota      <= sos_pkg::RST_OBJ_QUOTA;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                sos_pkg::REG_VALID_MIN:      r_valid_min      <= i_cfg_data;
                sos_pkg::REG_VALID_MAX:      r_valid_max      <= i_cfg_data;
                sos_pkg::REG_OBJECT_LIMIT:   r_object_limit   <= i_cfg_data;
                sos_pkg::REG_JUMP_THRESHOLD: r_jump_threshold <= i_cfg_data;
                sos_pkg::REG_MIN_WIDTH:      r_min_width <= i_cfg_data[sos_pkg::WIDTH_W-1:0];
                sos_pkg::REG_OBJ_QUOTA:      r_obj_quota <= i_cfg_data[sos_pkg::ID_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, sweep state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_inside        <= 1'b0;
            r_run_start     <= '0;
            r_sum           <= '0;
            r_count         <= '0;
            r_prev_dist     <= '0;
            r_prev_ang      <= '0;
            r_objects_found <= '0;
            r_best_width    <= '0;
            r_best_angle    <= '0;
            r_best_id       <= '0;
            r_last          <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_ang   <= i_angle;
                        r_dist  <= i_distance;
                        r_last  <= i_last_point;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!r_inside) begin
                        if (is_obj) begin
                            r_inside    <= 1'b1;
                            r_run_start <= r_ang;
                            r_sum       <= sos_pkg::SUM_W'(r_dist);
                            r_count     <= sos_pkg::CNT_W'(1);
                        end
                    end else begin
                        r_sum   <= n_sum;
                        r_count <= n_count;
                        if (run_end) begin
                            r_inside <= 1'b0;
                        end
                    end
                    if (qualify) begin
                        r_pend_id       <= n_id;
                        r_pend_ctr      <= run_ctr;
                        r_pend_width    <= run_width;
                        r_objects_found <= n_id;
                        // Ties keep the earlier object.
                        if ((r_objects_found == '0) || (run_width < r_best_width)) begin
                            r_best_width <= run_width;
                            r_best_angle <= run_ctr;
                            r_best_id    <= n_id;
                        end
                    end
                    r_prev_dist <= r_dist;
                    r_prev_ang  <= r_ang;
                    if (qualify) begin
                        r_state <= S_DIV;
                    end else if (r_last) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= sos_pkg::KIND_OBJECT;
                        r_out_id    <= r_pend_id;
                        r_out_ctr   <= r_pend_ctr;
                        r_out_width <= r_pend_width;
                        r_out_avg   <= avg_capped;
                        r_out_last  <= 1'b0;
                        r_state     <= S_OUT;
                    end
                end
                S_FIN: begin
                    // Load the final result of the sweep and start a new sweep.
                    r_out_valid <= 1'b1;
                    r_out_last  <= 1'b1;
                    r_out_avg   <= '0;
                    if (r_objects_found != '0) begin
                        r_out_kind  <= sos_pkg::KIND_SMALLEST;
                        r_out_id    <= r_best_id;
                        r_out_ctr   <= r_best_angle;
                        r_out_width <= r_best_width;
                    end else begin
                        r_out_kind  <= sos_pkg::KIND_NO_TARGET;
                        r_out_id    <= '0;
                        r_out_ctr   <= '0;
                        r_out_width <= '0;
                    end
                    r_inside        <= 1'b0;
                    r_run_start     <= '0;
                    r_sum           <= '0;
                    r_count         <= '0;
                    r_prev_dist     <= '0;
                    r_prev_ang      <= '0;
                    r_objects_found <= '0;
                    r_best_width    <= '0;
                    r_best_angle    <= '0;
                    r_best_id       <= '0;
                    r_last          <= 1'b0;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    if (out_xfer) begin
                        r_out_valid <= 1'b0;
                        r_state     <= r_last ? S_FIN : S_IDLE;
                    end
                end
                default: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_object_id    = r_out_id;
    assign o_mid_angle    = r_out_ctr;
    assign o_object_width = r_out_width;
    assign o_avg_distance = r_out_avg;
    assign o_last         = r_out_last;
    assign o_cfg_ready    = 1'b1;

    // A result is only ever presented while the sequencer waits on the output.
    a_out_in_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("result valid outside the output state");

    // The divider only runs while the sequencer waits for it.
    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == S_DIV))
        else $error("divider busy outside the divide state");

    // An open run always has at least one point, so the divisor is never zero.
    a_run_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inside |-> (r_count != '0))
        else $error("open run with zero point count");

    // The final result of a sweep leaves the sweep state cleared.
    a_sweep_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_out_last) |=> ((r_objects_found == '0) && !r_inside))
        else $error("sweep state not cleared after final result");

    // Object results always carry a one-based id.
    a_object_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == sos_pkg::KIND_OBJECT)) |-> (r_out_id != '0))
        else $error("object result with zero id");

endmodule

// ===== sv/sos_div.sv =====
// Restoring serial divider, one quotient bit per cycle, for the run average.
// Depends on sos_pkg for the sum and count widths.
`timescale 1ns / 1ps

module sos_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sos_pkg::SUM_W-1:0]  i_dividend,
    input  logic [sos_pkg::CNT_W-1:0]  i_divisor,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [sos_pkg::SUM_W-1:0]  o_quotient
);

    localparam int STEP_W = $clog2(sos_pkg::SUM_W);

    logic                      r_busy, n_busy;
    logic                      r_done, n_done;
    logic [STEP_W-1:0]         r_step, n_step;
    logic [sos_pkg::SUM_W-1:0] r_num, n_num;
    logic [sos_pkg::SUM_W-1:0] r_quo, n_quo;
    logic [sos_pkg::CNT_W-1:0] r_den, n_den;
    logic [sos_pkg::CNT_W-1:0] r_rem, n_rem;
    logic [sos_pkg::CNT_W:0]   rem_shift;
    logic                      fits;

    always_comb begin
        rem_shift = {r_rem, r_num[sos_pkg::SUM_W-1]};
        fits      = rem_shift >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_num  = r_num;
        n_quo  = r_quo;
        n_den  = r_den;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = STEP_W'(sos_pkg::SUM_W - 1);
            n_num  = i_dividend;
            n_den  = i_divisor;
            n_rem  = '0;
            n_quo  = '0;
        end else if (r_busy) begin
            n_num = {r_num[sos_pkg::SUM_W-2:0], 1'b0};
            n_quo = {r_quo[sos_pkg::SUM_W-2:0], fits};
            n_rem = fits ? sos_pkg::CNT_W'(rem_shift - {1'b0, r_den})
                         : rem_shift[sos_pkg::CNT_W-1:0];
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_num  <= n_num;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_rem  <= n_rem;
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
